FILE: rtl/oaht_pkg.sv
package oaht_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int MOD_W          = 11;
    localparam int MOD_RESET      = 823;
    localparam int WORD_W         = 32;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int ENTRY_W        = 11;
    localparam int DIV_CNT_W      = 5;
    localparam int S_DATA_W       = 104;
    localparam int M_DATA_W       = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CMP,
        S_CLR,
        S_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic div_step;
        logic rd;
        logic adv;
        logic resolve;
        logic clr_write;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic div_last;
        logic probe_done;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/oaht_ctrl.sv
module oaht_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  oaht_pkg::dp_status_t  st,
    output oaht_pkg::ctrl_cmd_t   cmd
);
    import oaht_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT_CLR: if (st.clr_last) state_next = S_IDLE;
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = st.is_clear ? S_CLR : S_DIV;
                end
            end
            S_DIV:  if (st.div_last) state_next = S_READ;
            S_READ: state_next = S_CMP;
            S_CMP:  state_next = st.probe_done ? S_FIN : S_READ;
            S_CLR:  if (st.clr_last) state_next = S_FIN;
            S_FIN:  if (st.out_free) state_next = S_IDLE;
            default: state_next = S_INIT_CLR;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_INIT_CLR: cmd.clr_write = 1'b1;
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_DIV:  cmd.div_step = 1'b1;
            S_READ: cmd.rd = 1'b1;
            S_CMP: begin
                cmd.resolve = st.probe_done;
                cmd.adv     = !st.probe_done;
            end
            S_CLR:  cmd.clr_write = 1'b1;
            S_FIN:  cmd.load_out = st.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: rtl/oaht_dp.sv
module oaht_dp #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [oaht_pkg::MOD_W-1:0]        cfg_wdata,
    input  logic [oaht_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [oaht_pkg::M_DATA_W-1:0]     m_tdata,
    input  oaht_pkg::ctrl_cmd_t               cmd,
    output oaht_pkg::dp_status_t              st
);
    import oaht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = IDX_W + 1;
    localparam int MEM_W = 3 * WORD_W;

    logic [MOD_W-1:0]     mod_reg;
    cmd_t                 cmd_reg;
    logic [WORD_W-1:0]    key_reg, hash_reg, val_reg, dvd_reg;
    logic [MOD_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [IDX_W-1:0]     idx_reg, clr_addr_reg;
    logic [CNT_W-1:0]     n_reg, count_reg;
    logic [MEM_W-1:0]     mem [TABLE_SIZE];
    logic [MEM_W-1:0]     rd_reg;
    status_t              res_status_reg;
    logic [WORD_W-1:0]    res_key_reg, res_val_reg;
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;

    logic [MOD_W-1:0]       divisor;
    logic [MOD_W:0]         rem_sh, rem_sub;
    logic [MOD_W-1:0]       rem_new;
    logic [IDX_W+MOD_W-1:0] rem_wide;
    logic [WORD_W-1:0]      in_hash, rd_hash, rd_key, rd_val;
    logic                   empty, hit, last_probe;
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [MEM_W-1:0]       wdata;
    logic [CNT_W+ENTRY_W-1:0] cnt_wide;

    assign divisor = (mod_reg == '0) ? MOD_W'(1) : mod_reg;
    assign rem_sh  = {rem_reg, dvd_reg[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign rem_new = (rem_sh >= {1'b0, divisor}) ? rem_sub[MOD_W-1:0] : rem_sh[MOD_W-1:0];
    assign rem_wide = {{IDX_W{1'b0}}, rem_new};

    assign in_hash = (s_tdata[65:34] == '0) ? WORD_W'(1) : s_tdata[65:34];
    assign {rd_val, rd_key, rd_hash} = rd_reg;
    assign empty      = (rd_hash == '0);
    assign hit        = (rd_hash == hash_reg) && (rd_key == key_reg);
    assign last_probe = (n_reg == CNT_W'(TABLE_SIZE - 1));

    assign st.is_clear   = (cmd_t'(s_tdata[1:0]) == CMD_CLEAR);
    assign st.div_last   = (div_cnt_reg == '1);
    assign st.probe_done = empty || hit || last_probe;
    assign st.clr_last   = (clr_addr_reg == '1);
    assign st.out_free   = !m_valid_reg || m_tready;

    always_comb begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = {val_reg, key_reg, hash_reg};
        if (cmd.clr_write) begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end else if (cmd.resolve) begin
            case (cmd_reg)
                CMD_INSERT: we = hit || empty;
                CMD_REMOVE: begin
                    we    = hit && !empty;
                    wdata = {rd_val, rd_key, {WORD_W{1'b0}}};
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd) begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cmd_reg  <= cmd_t'(s_tdata[1:0]);
            key_reg  <= s_tdata[33:2];
            hash_reg <= in_hash;
            dvd_reg  <= in_hash;
            val_reg  <= s_tdata[97:66];
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_new;
        end
        if (cmd.div_step && st.div_last) begin
            idx_reg <= rem_wide[IDX_W-1:0];
            n_reg   <= '0;
        end else if (cmd.adv) begin
            idx_reg <= idx_reg + IDX_W'(n_reg + CNT_W'(1));
            n_reg   <= n_reg + CNT_W'(1);
        end
        if (cmd.resolve) begin
            res_key_reg    <= '0;
            res_val_reg    <= '0;
            res_status_reg <= ST_OK;
            case (cmd_reg)
                CMD_INSERT: if (!hit && !empty) res_status_reg <= ST_FULL;
                default: begin
                    if (hit && !empty) begin
                        res_key_reg <= rd_key;
                        res_val_reg <= rd_val;
                    end else begin
                        res_status_reg <= ST_NOT_FOUND;
                    end
                end
            endcase
        end else if (cmd.clr_write && st.clr_last) begin
            res_key_reg    <= '0;
            res_val_reg    <= '0;
            res_status_reg <= ST_OK;
        end
        if (cmd.load_out) begin
            m_data_reg <= {3'b000, cnt_wide[ENTRY_W-1:0], res_val_reg, res_key_reg,
                           res_status_reg};
        end
    end

    assign cnt_wide = {{ENTRY_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg      <= MOD_W'(MOD_RESET);
            div_cnt_reg  <= '0;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                mod_reg <= cfg_wdata;
            end
            if (cmd.start) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.clr_write) begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                if (st.clr_last) begin
                    count_reg <= '0;
                end
            end else if (cmd.resolve) begin
                if (cmd_reg == CMD_INSERT && empty) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else if (cmd_reg == CMD_REMOVE && hit && !empty && count_reg != '0) begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: rtl/open_address_hash_table.sv
// Key/value store with open addressing and triangular probing over a table of
// TABLE_SIZE slots held in one single-port-write memory. Each input beat is one
// command and gives one result beat. Insert, lookup and remove first run the
// bit-serial remainder that gives the first slot (hash mod bucket_modulus), then
// probe slots, each probe costing a memory read plus a compare; the beat is
// accepted in S_IDLE and the result loaded in S_FIN. Clear sweeps the memory one
// slot a cycle. After reset the same sweep runs once with s_tready low. The result
// register lets the next command be accepted while a result waits on m_tready.
module open_address_hash_table #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [oaht_pkg::MOD_W-1:0]    cfg_wdata,   // bucket_modulus
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [oaht_pkg::S_DATA_W-1:0] s_tdata,     // command, key, key_hash, value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oaht_pkg::M_DATA_W-1:0] m_tdata      // status, key_out, value_out, entry_count
);
    import oaht_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    oaht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    oaht_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

FILE: tb/open_address_hash_table_tb.sv
`timescale 1ns / 100ps

module open_address_hash_table_tb;
    import oaht_pkg::*;

    localparam int SLOTS     = TABLE_SIZE_DEF;
    localparam int MAX_CYC   = 1500000;
    localparam int POOL_SIZE = 48;

    typedef struct packed {
        status_t          st;
        logic [31:0]      key_o;
        logic [31:0]      val_o;
        logic [ENTRY_W-1:0] cnt;
    } table_reply_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [MOD_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // command, key, key_hash, value
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;       // status, key_out, value_out, entry_count

    logic [31:0]        mdl_hash [SLOTS];
    logic [31:0]        mdl_key  [SLOTS];
    logic [31:0]        mdl_val  [SLOTS];
    int                 mdl_count;
    logic [MOD_W-1:0]   mdl_modulus;

    table_reply_t       pending_replies[$];
    logic [31:0]        pool_key [POOL_SIZE];
    logic [31:0]        pool_hash[POOL_SIZE];
    int                 fail_count = 0;
    int                 reply_count = 0;
    int                 sent_count = 0;
    int                 cycle_count = 0;
    int                 full_seen = 0;
    bit                 no_idle = 1'b0;
    int                 rx_stall = 0;

    open_address_hash_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC) begin
            $display("%0t: timeout with %0d replies pending", $time, pending_replies.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic table_reply_t apply_command(cmd_t cmd, logic [31:0] k,
                                                   logic [31:0] h_in, logic [31:0] v);
        table_reply_t r;
        logic [31:0] h;
        logic [31:0] m;
        logic [31:0] idx;
        logic [31:0] stride;
        int n;
        bit hit;
        bit empty_seen;
        h = (h_in == 0) ? 32'd1 : h_in;
        m = (mdl_modulus == 0) ? 32'd1 : 32'(mdl_modulus);
        idx = (h % m) & (SLOTS - 1);
        stride = 0;
        hit = 0;
        empty_seen = 0;
        r = '{st: ST_OK, key_o: 0, val_o: 0, cnt: 0};
        if (cmd == CMD_CLEAR) begin
            for (n = 0; n < SLOTS; n++) mdl_hash[n] = 0;
            mdl_count = 0;
        end else begin
            for (n = 0; n < SLOTS; n++) begin
                if (mdl_hash[idx] == 0) begin
                    empty_seen = 1;
                    break;
                end
                if (mdl_hash[idx] == h && mdl_key[idx] == k) begin
                    hit = 1;
                    break;
                end
                stride++;
                idx = (idx + stride) & (SLOTS - 1);
            end
            if (cmd == CMD_INSERT) begin
                if (hit) begin
                    mdl_key[idx] = k;
                    mdl_val[idx] = v;
                end else if (empty_seen) begin
                    mdl_hash[idx] = h;
                    mdl_key[idx] = k;
                    mdl_val[idx] = v;
                    mdl_count++;
                end else begin
                    r.st = ST_FULL;
                end
            end else if (!hit) begin
                r.st = ST_NOT_FOUND;
            end else begin
                r.key_o = mdl_key[idx];
                r.val_o = mdl_val[idx];
                if (cmd == CMD_REMOVE) begin
                    mdl_hash[idx] = 0;
                    if (mdl_count > 0) mdl_count--;
                end
            end
        end
        r.cnt = ENTRY_W'(mdl_count);
        return r;
    endfunction

    task automatic send_beat(cmd_t cmd, logic [31:0] k, logic [31:0] h, logic [31:0] v);
        int gap;
        gap = (!no_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        repeat (gap) @(negedge aclk);
        s_tdata = {6'd0, v, h, k, cmd};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(apply_command(cmd, k, h, v));
        sent_count++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // hold off until every reply is back and the block has settled
    task automatic drain();
        while (pending_replies.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_modulus(logic [MOD_W-1:0] m);
        drain();
        cfg_wdata = m;
        cfg_we = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        mdl_modulus = m;
    endtask

    always @(negedge aclk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        table_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reply_count++;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (want.st == ST_FULL) full_seen++;
                if (m_tdata[1:0] !== want.st || m_tdata[33:2] !== want.key_o ||
                    m_tdata[65:34] !== want.val_o || m_tdata[76:66] !== want.cnt) begin
                    $display("%0t: mismatch expected st=%0d key=%h val=%h cnt=%0d",
                             $time, want.st, want.key_o, want.val_o, want.cnt);
                    $display("%0t:          actual   st=%0d key=%h val=%h cnt=%0d",
                             $time, m_tdata[1:0], m_tdata[33:2], m_tdata[65:34],
                             m_tdata[76:66]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_basic_commands();
        send_beat(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
        send_beat(CMD_INSERT, 32'h0, 32'h0, 32'h0);
        send_beat(CMD_LOOKUP, 32'h0, 32'h1, 32'h0);
        send_beat(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
        send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_INSERT, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_beat(CMD_INSERT, 32'h0000_0001, 32'h0000_0337, 32'hCAFE_0001);
        send_beat(CMD_LOOKUP, 32'hA5A5_A5A5, 32'hFFFF_FFFE, 32'h0);
        send_beat(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_LOOKUP, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_REMOVE, 32'h0, 32'h0, 32'h0);
        send_beat(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_LOOKUP, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_INSERT, 32'h7, 32'h8000_0000, 32'h8000_0000);
        send_beat(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_modulus_extremes();
        logic [MOD_W-1:0] mods[4] = '{11'd0, 11'd2047, 11'd1, 11'd1024};
        foreach (mods[i]) begin
            set_modulus(mods[i]);
            send_beat(CMD_INSERT, 32'h11, 32'h0000_07FE, 32'h1);
            send_beat(CMD_INSERT, 32'h22, 32'hFFFF_FFFF, 32'h2);
            send_beat(CMD_LOOKUP, 32'h11, 32'h0000_07FE, 32'h0);
            send_beat(CMD_REMOVE, 32'h22, 32'hFFFF_FFFF, 32'h0);
            send_beat(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        end
        set_modulus(11'd823);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < SLOTS; i++)
            send_beat(CMD_INSERT, 32'h1000_0000 + i, $urandom, $urandom);
        send_beat(CMD_INSERT, 32'h2000_0000, 32'h0000_0005, 32'h1);
        send_beat(CMD_LOOKUP, 32'h2000_0000, 32'h0000_0005, 32'h0);
        send_beat(CMD_REMOVE, 32'h2000_0000, 32'h0000_0005, 32'h0);
        drain();
        for (int i = 0; i < SLOTS; i++) begin
            if (mdl_key[i] == 32'h1000_0003) begin
                send_beat(CMD_REMOVE, mdl_key[i], mdl_hash[i], 32'h0);
                break;
            end
        end
        send_beat(CMD_INSERT, 32'h2000_0000, 32'h0000_0005, 32'h9);
        send_beat(CMD_LOOKUP, 32'h2000_0000, 32'h0000_0005, 32'h0);
        send_beat(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_random_traffic(int count, logic [MOD_W-1:0] m);
        int sel;
        int p;
        cmd_t cmd;
        set_modulus(m);
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_key[i]  = $urandom;
            pool_hash[i] = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
        end
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            p = $urandom_range(0, POOL_SIZE - 1);
            if (sel < 2) cmd = CMD_CLEAR;
            else if (sel < 45) cmd = CMD_INSERT;
            else if (sel < 75) cmd = CMD_LOOKUP;
            else cmd = CMD_REMOVE;
            if ($urandom_range(0, 9) == 0)
                send_beat(cmd, $urandom, $urandom, $urandom);
            else
                send_beat(cmd, pool_key[p], pool_hash[p], $urandom);
        end
    endtask

    initial begin
        mdl_modulus = 11'(MOD_RESET);
        mdl_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            mdl_hash[i] = 0;
            mdl_key[i]  = 0;
            mdl_val[i]  = 0;
        end
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        test_basic_commands();
        test_modulus_extremes();
        test_full_table();
        test_random_traffic(200, 11'd7);
        test_random_traffic(200, 11'd1021);
        test_random_traffic(150, 11'd2047);
        test_random_traffic(100, 11'd1);
        no_idle = 1'b1;
        test_random_traffic(100, 11'd823);
        drain();
        $display("Sent %0d commands, checked %0d replies (%0d full), across 7 modulus values",
                 sent_count, reply_count, full_seen);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
